// ===== rtl/core/tty_line_editor_core_assert.svh =====
// Assertion macros for the tty line editor core.
// Included by the top level; no other dependencies.
`ifndef TTY_LINE_EDITOR_CORE_ASSERT_SVH
`define TTY_LINE_EDITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Plain invariant, sampled on every edge outside reset.
`define TLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tty line editor assertion failed");
// Same-cycle implication.
`define TLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tty line editor assertion failed");
// Next-cycle implication.
`define TLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tty line editor assertion failed");
`else
`define TLE_ASSERT(lbl, clk, rstn, prop)
`define TLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/tle_pkg.sv =====
// Shared constants and types for the tty line editor core.
// No dependencies; every module and interface imports this package.
package tle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
  localparam int CAP_W      = 6;
  localparam int CODE_W     = 8;
  localparam int CMP_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DELETE   = 1'd1;

  localparam logic [CAP_W-1:0]  CAPACITY_RST = 6'd32;
  localparam logic [CODE_W-1:0] DELETE_RST   = 8'd127;

  localparam logic [CODE_W-1:0] CODE_NUL = 8'd0;
  localparam logic [CODE_W-1:0] CODE_BS  = 8'd8;
  localparam logic [CODE_W-1:0] CODE_NL  = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SP  = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HI = 8'd126;

  localparam logic [1:0] LAST_ERASE_STEP = 2'd2;

  // Source of the byte loaded into the output register
  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_BS,
    SRC_SP,
    SRC_LINE
  } src_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [CODE_W-1:0] delete_code;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic erase;
    logic clear_fill;
    logic rd_start;
    logic rd_next;
    logic emit;
    src_t src;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic hit_erase;
    logic hit_store;
    logic fill_zero;
    logic finish;
    logic dump_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/tle_if.sv =====
// Request channel interfaces for key events and result bytes.
// Depends on tle_pkg for field widths.
interface tle_in_if import tle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_press;
  logic [CODE_W-1:0] char_code;

  modport source (output valid, is_press, char_code, input ready);
  modport sink   (input valid, is_press, char_code, output ready);
endinterface

interface tle_out_if import tle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CODE_W-1:0] data_byte;
  logic              is_last;

  modport source (output valid, kind, data_byte, is_last, input ready);
  modport sink   (input valid, kind, data_byte, is_last, output ready);
endinterface

// ===== rtl/core/tle_regs.sv =====
// APB configuration registers: line capacity and delete code.
// Depends on tle_pkg.
module tle_regs import tle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CAP_W-1:0]     capacity_r;
  logic [CODE_W-1:0]    delete_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
      delete_r   <= DELETE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY: capacity_r <= pwdata[CAP_W-1:0];
        REG_DELETE:   delete_r   <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_CAPACITY: prdata = APB_DATA_W'(capacity_r);
      REG_DELETE:   prdata = APB_DATA_W'(delete_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.capacity    = capacity_r;
  assign cfg.delete_code = delete_r;

endmodule

// ===== rtl/core/tle_datapath.sv =====
// Datapath: captured event, line store, fill count, read index, output register.
// Depends on tle_pkg; driven by tle_ctrl commands.
module tle_datapath import tle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              in_is_press,
  input  logic [CODE_W-1:0] in_char_code,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_kind,
  output logic [CODE_W-1:0] out_data_byte,
  output logic              out_is_last
);

  logic [CODE_W-1:0] line_mem [LINE_DEPTH];

  logic              press_r;
  logic [CODE_W-1:0] code_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] idx_r;
  logic [FILL_W-1:0] idx_nxt;
  logic [CODE_W-1:0] rd_data_r;
  logic              out_valid_r;
  logic              kind_r;
  logic [CODE_W-1:0] byte_r;
  logic              last_r;

  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic [CODE_W-1:0] emit_byte;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      press_r <= in_is_press;
      code_r  <= in_char_code;
    end
  end

  // Clamp capacity into 1..LINE_DEPTH
  always_comb begin
    cap_ext = CMP_W'(cfg.capacity);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(LINE_DEPTH)) begin
      eff_cap = CMP_W'(LINE_DEPTH);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear_fill) begin
      fill_nxt = '0;
    end else if (cmd.store) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.erase) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_mem[fill_r[ADDR_W-1:0]] <= code_r;
    end
  end

  assign idx_nxt = cmd.rd_start ? '0 : idx_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_start || cmd.rd_next) begin
      idx_r     <= idx_nxt;
      rd_data_r <= line_mem[idx_nxt[ADDR_W-1:0]];
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_CODE: emit_byte = code_r;
      SRC_BS:   emit_byte = CODE_BS;
      SRC_SP:   emit_byte = CODE_SP;
      SRC_LINE: emit_byte = rd_data_r;
      default:  emit_byte = code_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r <= (cmd.src == SRC_LINE);
      byte_r <= emit_byte;
      last_r <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_data_byte = byte_r;
  assign out_is_last   = last_r;

  assign status.ignore    = !press_r || (code_r == CODE_NUL);
  assign status.hit_erase = (code_r == CODE_BS) || (code_r == cfg.delete_code);
  assign status.hit_store = (code_r == CODE_NL) ||
                            ((code_r >= PRINT_LO) && (code_r <= PRINT_HI));
  assign status.fill_zero = (fill_r == '0);
  assign status.finish    = (code_r == CODE_NL) || (CMP_W'(fill_r) >= eff_cap);
  assign status.dump_last = ((idx_r + FILL_W'(1)) == fill_r);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/core/tle_ctrl.sv =====
// Controller state machine: sequences decode, echo, erase and line dump.
// Depends on tle_pkg; drives tle_datapath through cmd_t.
module tle_ctrl import tle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ERASE,
    ST_ECHO,
    ST_DUMP
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.src   = SRC_CODE;
    in_ready  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.ignore) begin
          state_nxt = ST_IDLE;
        end else if (status.hit_erase) begin
          if (status.fill_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.erase = 1'b1;
            step_nxt  = '0;
            state_nxt = ST_ERASE;
          end
        end else if (status.hit_store) begin
          cmd.store = 1'b1;
          state_nxt = ST_ECHO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERASE: begin
        // backspace, space, backspace
        cmd.src  = (step_r == 2'd1) ? SRC_SP : SRC_BS;
        cmd.last = (step_r == LAST_ERASE_STEP);
        if (status.out_free) begin
          cmd.emit = 1'b1;
          step_nxt = step_r + 2'd1;
          if (step_r == LAST_ERASE_STEP) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ECHO: begin
        cmd.src  = SRC_CODE;
        cmd.last = !status.finish;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.finish) begin
            cmd.rd_start = 1'b1;
            state_nxt    = ST_DUMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        cmd.src  = SRC_LINE;
        cmd.last = status.dump_last;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.dump_last) begin
            cmd.clear_fill = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/tty_line_editor_core.sv =====
// Echo: key captured in ST_IDLE, stored in ST_DECODE, put in the output register from ST_ECHO.
// States per key: ignored keys pass ST_IDLE and ST_DECODE, stored keys add ST_ECHO, an erase adds
// ST_ERASE for backspace, space, backspace, and a key that ends a line (at most 32 bytes) adds ST_ECHO and ST_DUMP.
// Unless the output stalls, the line dump streams one byte per cycle off the line store's single read port.
// Reset (synchronous, rst_n low): fill count zero, registers to capacity 32 and
// delete code 127, output empty; the line store is not cleared.
`include "tty_line_editor_core_assert.svh"

module tty_line_editor_core import tle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tle_in_if.sink                in_ch,
  tle_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  tle_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tle_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_is_press   (in_ch.is_press),
    .in_char_code  (in_ch.char_code),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_kind      (out_ch.kind),
    .out_data_byte (out_ch.data_byte),
    .out_is_last   (out_ch.is_last)
  );

  assign in_ch.ready = in_ready;

  // Never overwrite a result still held in the output register
  `TLE_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, status.out_free)
  // One key in flight at a time
  `TLE_ASSERT_NEXT(a_one_item, clk, rst_n, in_ch.valid && in_ready, !in_ready)
  // Read ahead only while line bytes remain
  `TLE_ASSERT_IMPL(a_rd_next, clk, rst_n, cmd.rd_next, !status.dump_last)
  // Line dump leaves an empty line
  `TLE_ASSERT_NEXT(a_clear, clk, rst_n, cmd.clear_fill, status.fill_zero)

endmodule
